/* hdl/fbpa_pkg.sv */
// Shared constants for the fixed-size block pool allocator.
package fbpa_pkg;

	localparam int POOL_DEPTH_DEF = 64;
	localparam int ADDR_WIDTH_DEF = 32;

	localparam int PADDR_W = 4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_MEM  = 2'd1;
	localparam logic [1:0] ST_NULL    = 2'd2;
	localparam logic [1:0] ST_BAD_CFG = 2'd3;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_SIZE   = 2'd1;
	localparam logic [1:0] REG_COUNT  = 2'd2;
	localparam logic [1:0] REG_BUFFER = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef logic [1:0] status_t;

endpackage

/* hdl/fixed_block_pool_allocator.sv */
// Top level of the fixed-size block pool allocator with its free stack and register port.
//
// The pool takes one request (allocate or free) in every clock cycle; busy is always low.
// Each request gives exactly one result word, shown for one cycle with done high after the
// request has passed the free stack memory, whose read data is registered, and then one result
// register; the receiver cannot stall results, so it must take every word. A register write
// rebuilds the free stack at once, without any clearing pass: entries that have not been pushed
// since the write read back as base_address plus index times the block size. Registers lie at
// byte addresses 0, 4, 8 and 12.
module fixed_block_pool_allocator #(
	parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF,
	parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [31:0]                  free_address,
	output logic                         done,
	output fbpa_pkg::status_t            status,
	output logic [31:0]                  block_address,
	output logic [6:0]                   free_count
);
	import fbpa_pkg::*;

	localparam int PtrW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int TopW  = $clog2(POOL_DEPTH + 1);
	localparam int CmpW  = (TopW > 7) ? TopW : 7;
	localparam int ProdW = PtrW + 16;

	logic [31:0] base_q;
	logic [15:0] size_q;
	logic [6:0]  count_q;
	logic [31:0] buffer_q;

	logic cfg_wr;
	logic cfg_ok;
	logic [22:0] need_size;
	logic [CmpW-1:0] count_ext;
	logic [CmpW-1:0] cap_ext;
	logic [TopW-1:0] cap;
	logic [TopW-1:0] top_init;

	logic [TopW-1:0] top_q;
	logic            dirty_q;
	logic [TopW-1:0] top_cur;
	logic [TopW-1:0] top_m1;
	logic [TopW-1:0] top_next;
	logic [POOL_DEPTH-1:0] valid_q;

	logic accept;
	logic pop_ok;
	logic push_ok;
	status_t status_new;
	logic [PtrW-1:0] rd_idx;
	logic [PtrW-1:0] wr_idx;
	logic [ADDR_WIDTH+31:0] fa_ext;
	logic [ADDR_WIDTH-1:0]  push_data;

	logic [ADDR_WIDTH-1:0] stack_mem [POOL_DEPTH];

	logic                  vld_s1;
	status_t               status_s1;
	logic                  pop_s1;
	logic                  hit_s1;
	logic [PtrW-1:0]       idx_s1;
	logic [ADDR_WIDTH-1:0] rd_data_s1;
	logic [TopW-1:0]       count_s1;

	logic [ProdW-1:0]       fill_off;
	logic [ADDR_WIDTH-1:0]  fill_addr;
	logic [ADDR_WIDTH-1:0]  addr_sel;
	logic [ADDR_WIDTH+31:0] ba_ext;
	logic [CmpW-1:0]        count_out_ext;

	logic    done_q;
	status_t status_q;
	logic [31:0] block_address_q;
	logic [6:0]  free_count_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[3:2])
			REG_BASE:   prdata = base_q;
			REG_SIZE:   prdata = {16'd0, size_q};
			REG_COUNT:  prdata = {25'd0, count_q};
			REG_BUFFER: prdata = buffer_q;
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			size_q   <= '0;
			count_q  <= '0;
			buffer_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BASE:   base_q   <= pwdata;
				REG_SIZE:   size_q   <= pwdata[15:0];
				REG_COUNT:  count_q  <= pwdata[6:0];
				REG_BUFFER: buffer_q <= pwdata;
				default:    base_q   <= base_q;
			endcase
		end
	end

	assign need_size = 23'(size_q) * 23'(count_q);
	assign cfg_ok    = buffer_q >= {9'd0, need_size};
	assign count_ext = CmpW'(count_q);
	assign cap_ext   = (count_ext > CmpW'(POOL_DEPTH)) ? CmpW'(POOL_DEPTH) : count_ext;
	assign cap       = cap_ext[TopW-1:0];
	assign top_init  = cfg_ok ? cap : '0;

	assign top_cur = dirty_q ? top_init : top_q;
	assign top_m1  = top_cur - TopW'(1);
	assign rd_idx  = top_m1[PtrW-1:0];
	assign wr_idx  = top_cur[PtrW-1:0];

	assign accept  = start & ~busy;
	assign pop_ok  = cfg_ok & (op == OP_ALLOC) & (top_cur != '0);
	assign push_ok = cfg_ok & (op == OP_FREE) & (free_address != 32'd0) & (top_cur < cap);

	assign fa_ext    = {{ADDR_WIDTH{1'b0}}, free_address};
	assign push_data = fa_ext[ADDR_WIDTH-1:0];

	always_comb begin
		priority if (!cfg_ok) begin
			status_new = ST_BAD_CFG;
		end else if (op == OP_ALLOC && top_cur == '0) begin
			status_new = ST_NO_MEM;
		end else if (op == OP_FREE && free_address == 32'd0) begin
			status_new = ST_NULL;
		end else begin
			status_new = ST_OK;
		end
	end

	always_comb begin
		priority if (accept && pop_ok) begin
			top_next = top_m1;
		end else if (accept && push_ok) begin
			top_next = top_cur + TopW'(1);
		end else begin
			top_next = top_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			dirty_q <= 1'b1;
			valid_q <= '0;
		end else begin
			top_q   <= top_next;
			dirty_q <= cfg_wr;
			if (cfg_wr) begin
				valid_q <= '0;
			end else if (accept && push_ok) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && push_ok) begin
			stack_mem[wr_idx] <= push_data;
		end
		rd_data_s1 <= stack_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= status_new;
		pop_s1    <= pop_ok;
		hit_s1    <= valid_q[rd_idx];
		idx_s1    <= rd_idx;
		count_s1  <= top_next;
	end

	assign fill_off      = ProdW'(idx_s1) * ProdW'(size_q);
	assign fill_addr     = ADDR_WIDTH'(base_q) + ADDR_WIDTH'(fill_off);
	assign addr_sel      = hit_s1 ? rd_data_s1 : fill_addr;
	assign ba_ext        = {32'd0, addr_sel};
	assign count_out_ext = CmpW'(count_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_q        <= status_s1;
		block_address_q <= pop_s1 ? ba_ext[31:0] : 32'd0;
		free_count_q    <= count_out_ext[6:0];
	end

	assign done          = done_q;
	assign status        = status_q;
	assign block_address = block_address_q;
	assign free_count    = free_count_q;

endmodule

/* sim/fixed_block_pool_allocator_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-size block pool allocator and its register port.
module fixed_block_pool_allocator_test;
	import fbpa_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_WORDS = 75;

	typedef struct packed {
		status_t     status;
		logic [31:0] addr;
		logic [6:0]  count;
	} pool_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              busy;
	logic              op = OP_ALLOC;
	logic [31:0]       free_address = '0;
	logic              done;
	status_t           status;
	logic [31:0]       block_address;
	logic [6:0]        free_count;

	logic [31:0] reg_base;
	logic [15:0] reg_size;
	logic [6:0]  reg_count;
	logic [31:0] reg_buffer;
	logic [31:0] pool_stack [DEPTH];
	int          pool_top;
	int          pool_cap;
	bit          pool_cfg_ok;

	pool_word_t  pending_results [$];
	logic [31:0] live_blocks [$];
	bit          no_idle;
	int          mismatches;
	int          words_sent;
	int          words_checked;
	int          reg_writes;
	int          cycles;

	fixed_block_pool_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.free_address  (free_address),
		.done          (done),
		.status        (status),
		.block_address (block_address),
		.free_count    (free_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words outstanding.", cycles,
				pending_results.size());
			$display("fixed_block_pool_allocator_test: FAIL");
			$finish;
		end
	end

	function automatic void rebuild_pool();
		logic [63:0] need;
		need = 64'(reg_size) * 64'(reg_count);
		pool_cfg_ok = {32'd0, reg_buffer} >= need;
		pool_cap = !pool_cfg_ok ? 0 : (reg_count > DEPTH) ? DEPTH : int'(reg_count);
		pool_top = pool_cap;
		for (int i = 0; i < DEPTH; i++)
			pool_stack[i] = (i < pool_cap) ? reg_base + 32'(i) * 32'(reg_size) : 32'd0;
	endfunction

	function automatic void set_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			REG_BASE:   reg_base = data;
			REG_SIZE:   reg_size = data[15:0];
			REG_COUNT:  reg_count = data[6:0];
			REG_BUFFER: reg_buffer = data;
			default: ;
		endcase
		rebuild_pool();
	endfunction

	function automatic logic [31:0] reg_value(logic [1:0] idx);
		case (idx)
			REG_BASE:   return reg_base;
			REG_SIZE:   return {16'd0, reg_size};
			REG_COUNT:  return {25'd0, reg_count};
			default:    return reg_buffer;
		endcase
	endfunction

	function automatic pool_word_t pool_request(logic req_op, logic [31:0] req_addr);
		pool_word_t w;
		w.status = ST_OK;
		w.addr = '0;
		if (!pool_cfg_ok) begin
			w.status = ST_BAD_CFG;
		end else if (req_op == OP_ALLOC) begin
			if (pool_top == 0) begin
				w.status = ST_NO_MEM;
			end else begin
				pool_top--;
				w.addr = pool_stack[pool_top];
			end
		end else if (req_addr == 32'd0) begin
			w.status = ST_NULL;
		end else if (pool_top < pool_cap) begin
			pool_stack[pool_top] = req_addr;
			pool_top++;
		end
		w.count = 7'(pool_top);
		return w;
	endfunction

	// Every result word is checked against the oldest predicted word.
	always @(posedge clk) begin
		pool_word_t w;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word: status %0d, address %h, count %0d", $time,
					status, block_address, free_count);
				mismatches++;
			end else begin
				w = pending_results.pop_front();
				words_checked++;
				if (status !== w.status) begin
					$display("%0t: status expected %0d, actual %0d", $time, w.status, status);
					mismatches++;
				end
				if (block_address !== w.addr) begin
					$display("%0t: block_address expected %h, actual %h", $time, w.addr,
						block_address);
					mismatches++;
				end
				if (free_count !== w.count) begin
					$display("%0t: free_count expected %0d, actual %0d", $time, w.count,
						free_count);
					mismatches++;
				end
			end
		end
	end

	task automatic send_word(input logic req_op, input logic [31:0] req_addr);
		int gap;
		pool_word_t w;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op <= req_op;
		free_address <= req_addr;
		do @(posedge clk); while (busy);
		w = pool_request(req_op, req_addr);
		if (req_op == OP_ALLOC && w.status == ST_OK)
			live_blocks.push_back(w.addr);
		pending_results.push_back(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic free_live_block();
		int k;
		logic [31:0] a;
		k = $urandom_range(0, live_blocks.size() - 1);
		a = live_blocks[k];
		live_blocks.delete(k);
		send_word(OP_FREE, a);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] data,
		output logic [31:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if (wr) begin
			set_reg(idx, data);
			reg_writes++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [31:0] base, input logic [31:0] size,
		input logic [31:0] count, input logic [31:0] buffer);
		logic [31:0] rd;
		drain();
		apb_xfer(1'b1, REG_BASE, base, rd);
		apb_xfer(1'b1, REG_SIZE, size, rd);
		apb_xfer(1'b1, REG_COUNT, count, rd);
		apb_xfer(1'b1, REG_BUFFER, buffer, rd);
		live_blocks.delete();
	endtask

	task automatic test_reset_pool();
		drain();
		send_word(OP_ALLOC, 32'hFFFF_FFFF);
		send_word(OP_FREE, 32'h0000_0001);
		send_word(OP_FREE, 32'd0);
	endtask

	task automatic test_small_pool();
		configure(32'h0000_1000, 32'h40, 32'd3, 32'hC0);
		repeat (4) send_word(OP_ALLOC, 32'd0);
		send_word(OP_FREE, 32'd0);
		send_word(OP_FREE, 32'h0000_1000);
		send_word(OP_FREE, 32'h0000_1040);
		send_word(OP_FREE, 32'h0000_1080);
		send_word(OP_FREE, 32'hFFFF_FFFF);
		send_word(OP_ALLOC, 32'hFFFF_FFFF);
	endtask

	task automatic test_bad_config();
		configure(32'h0000_1000, 32'h40, 32'd3, 32'hBF);
		send_word(OP_ALLOC, 32'd0);
		send_word(OP_FREE, 32'h0000_1000);
		send_word(OP_FREE, 32'd0);
	endtask

	// All-ones in every register: count saturates at the stack depth and addresses wrap.
	task automatic test_register_readback();
		logic [31:0] rd;
		drain();
		for (int i = 0; i < 4; i++) begin
			apb_xfer(1'b1, 2'(i), 32'hFFFF_FFFF, rd);
			apb_xfer(1'b0, 2'(i), 32'd0, rd);
			if (rd !== reg_value(2'(i))) begin
				$display("%0t: register %0d read expected %h, actual %h", $time, i,
					reg_value(2'(i)), rd);
				mismatches++;
			end
		end
		live_blocks.delete();
		repeat (3) send_word(OP_ALLOC, 32'd0);
		send_word(OP_FREE, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_traffic();
		int kind;
		int r;
		logic [31:0] size;
		logic [31:0] count;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			kind = $urandom_range(0, 9);
			size = (kind == 9) ? 32'd0 : $urandom_range(1, 16'hFFFF);
			case (kind)
				0: begin
					count = $urandom_range(1, 127);
					configure($urandom, size, count, size * count - 1);
				end
				1: configure($urandom, size, $urandom_range(65, 127), 32'hFFFF_FFFF);
				2: configure($urandom, size, 32'd64, size * 64);
				3: configure($urandom, size, 32'd0, $urandom);
				default: begin
					count = $urandom_range(1, 8);
					configure($urandom, size, count,
						($urandom_range(0, 1) == 0) ? size * count + $urandom_range(0, 3)
							: 32'hFFFF_FFFF);
				end
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (PHASE_WORDS) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					send_word(OP_ALLOC, $urandom);
				else if (r < 80 && live_blocks.size() > 0)
					free_live_block();
				else if (r < 88)
					send_word(OP_FREE, 32'd0);
				else
					send_word(OP_FREE, $urandom);
			end
		end
	endtask

	initial begin
		reg_base = '0;
		reg_size = '0;
		reg_count = '0;
		reg_buffer = '0;
		rebuild_pool();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_pool();
		test_small_pool();
		test_bad_config();
		test_register_readback();
		test_random_traffic();
		drain();
		repeat (10) @(negedge clk);
		$display("Sent %0d request words and checked %0d result words across %0d register writes,",
			words_sent, words_checked, reg_writes);
		$display("including empty, full, null, bad-configuration, saturated and wrapping pools.");
		if (mismatches == 0)
			$display("fixed_block_pool_allocator_test: PASS");
		else
			$display("fixed_block_pool_allocator_test: FAIL");
		$finish;
	end

endmodule
